[rtl/positional_list_engine_top_defines.svh]
// Assertion macros shared by the positional list engine RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// Checked on every clock edge outside reset
`define PLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define PLE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/ple_pkg.sv]
// Package for the positional list engine: field widths, command and status codes.
// No dependencies; used by positional_list_engine_top.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

    localparam int unsigned CMD_W    = 4;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned POS2_W   = 6;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT     = 4'd0,
        CMD_PUSH_FRONT = 4'd1,
        CMD_PUSH_BACK  = 4'd2,
        CMD_ERASE      = 4'd3,
        CMD_POP_FRONT  = 4'd4,
        CMD_POP_BACK   = 4'd5,
        CMD_SWAP       = 4'd6,
        CMD_READ       = 4'd7,
        CMD_CLEAR      = 4'd8
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

endpackage

`default_nettype wire

[rtl/ple_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the list entries of the positional list engine.
`timescale 1ns / 1ps
`default_nettype none

module ple_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/positional_list_engine_top.sv]
// Positional list engine: ordered list of signed 32-bit values kept in one RAM.
// Depends on ple_pkg, ple_ram and positional_list_engine_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "positional_list_engine_top_defines.svh"

// The engine takes one command at a time and stalls its input until the result
// is in the output register; a finished result may wait there while the next
// command is taken. Entries live in a single-port-pair RAM and every move goes
// through it, one element at a time (read, then write back one place over), so
// the cost follows the number of entries moved. Swap and read use the RAM
// without a move; a pop from the back, clear, refused and unknown commands go
// straight to the result. A stalled receiver that holds a result in the output
// register keeps the next result waiting. Reset needs no clearing pass.
module positional_list_engine_top
    import ple_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // command channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic        [CMD_W-1:0]    i_cmd,
    input  wire logic        [POS_W-1:0]    i_position,
    input  wire logic        [POS2_W-1:0]   i_second_position,
    input  wire logic signed [DATA_W-1:0]   i_item_value,
    // result channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic             [STATUS_W-1:0] o_status,
    output logic signed      [DATA_W-1:0]   o_read_value,
    output logic             [COUNT_W-1:0]  o_count,
    output logic                            o_empty
);

    localparam int unsigned AW   = $clog2(DEPTH);
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MV_RD,
        S_MV_WR,
        S_PUT,
        S_SW_RD1,
        S_SW_RD2,
        S_SW_WR1,
        S_SW_WR2,
        S_RD1,
        S_RD2,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_idx;
    logic [AW-1:0]         r_tgt;
    logic                  r_dir;     // 1: walk upwards (erase), 0: downwards (insert)
    logic                  r_ins;
    logic [AW-1:0]         r_pos;
    logic [AW-1:0]         r_pos2;
    logic [DATA_W-1:0]     r_val;
    logic [DATA_W-1:0]     r_tmp;
    logic [DATA_W-1:0]     r_rd;
    t_status               r_status;
    logic                  r_out_valid;

    logic [AW-1:0]         n_step;
    t_status               n_status;
    t_state                n_launch;
    logic [CW-1:0]         n_idle_count;
    logic [AW-1:0]         n_idx;
    logic [AW-1:0]         n_tgt;
    logic                  cmd_grows;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_W-1:0]     ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_W-1:0]     ram_rdata;

    logic                  in_xfer;
    logic                  out_xfer;
    logic                  done_load;
    logic                  is_full;
    logic                  no_entries;
    logic [CMPW-1:0]       cnt_ext;
    logic [CMPW-1:0]       pos_ext;
    logic [CMPW-1:0]       pos2_ext;
    logic                  pos_gt;
    logic                  pos_ge;
    logic                  pos2_ge;
    logic [AW-1:0]         pos_a;
    logic [AW-1:0]         pos2_a;
    logic [AW-1:0]         cnt_a;
    logic [AW-1:0]         last_a;
    logic [CMPW-1:0]       count_out;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign done_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Range checks against the current count
    assign cnt_ext      = CMPW'(r_count);
    assign pos_ext      = CMPW'(i_position);
    assign pos2_ext     = CMPW'(i_second_position);
    assign is_full      = (r_count >= CW'(DEPTH));
    assign no_entries   = (r_count == '0);
    assign pos_gt       = (pos_ext > cnt_ext);
    assign pos_ge       = (pos_ext >= cnt_ext);
    assign pos2_ge      = (pos2_ext >= cnt_ext);
    assign pos_a        = pos_ext[AW-1:0];
    assign pos2_a       = pos2_ext[AW-1:0];
    assign cnt_a        = cnt_ext[AW-1:0];
    assign last_a       = AW'(r_count - CW'(1));

    // Command decode: status, first state, count and move bounds
    always_comb begin
        n_status     = ST_OK;
        n_launch     = S_DONE;
        n_idle_count = r_count;
        cmd_grows    = 1'b0;
        n_idx        = cnt_a;
        n_tgt        = cnt_a;
        unique case (i_cmd)
            CMD_INSERT, CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                cmd_grows = 1'b1;
                if (i_cmd == CMD_INSERT) begin
                    n_tgt = pos_a;
                end else if (i_cmd == CMD_PUSH_FRONT) begin
                    n_tgt = '0;
                end
                if (is_full) begin
                    n_status = ST_FULL;
                end else if (i_cmd == CMD_INSERT && pos_gt) begin
                    n_status = ST_RANGE;
                end else begin
                    n_launch = S_MV_RD;
                end
            end
            CMD_ERASE, CMD_POP_FRONT: begin
                n_idx = (i_cmd == CMD_ERASE) ? pos_a : '0;
                n_tgt = last_a;
                if (no_entries) begin
                    n_status = ST_EMPTY;
                end else if (i_cmd == CMD_ERASE && pos_ge) begin
                    n_status = ST_RANGE;
                end else begin
                    n_launch = S_MV_RD;
                end
            end
            CMD_POP_BACK: begin
                if (no_entries) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_idle_count = r_count - CW'(1);
                end
            end
            CMD_SWAP: begin
                if (no_entries) begin
                    n_status = ST_EMPTY;
                end else if (pos_ge || pos2_ge) begin
                    n_status = ST_RANGE;
                end else begin
                    n_launch = S_SW_RD1;
                end
            end
            CMD_READ: begin
                if (no_entries) begin
                    n_status = ST_EMPTY;
                end else if (pos_ge) begin
                    n_status = ST_RANGE;
                end else begin
                    n_launch = S_RD1;
                end
            end
            CMD_CLEAR: begin
                n_idle_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Shared index stepper: the neighbour of the element being moved
    assign n_step = r_dir ? (r_idx + AW'(1)) : (r_idx - AW'(1));

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_rdata;
        ram_raddr = n_step;
        unique case (r_state)
            S_MV_WR: begin
                ram_we = 1'b1;
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_wdata = r_val;
            end
            S_SW_RD1, S_RD1: begin
                ram_raddr = r_pos;
            end
            S_SW_RD2: begin
                ram_raddr = r_pos2;
            end
            S_SW_WR1: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
            end
            S_SW_WR2: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos2;
                ram_wdata = r_tmp;
            end
            default: begin
            end
        endcase
    end

    ple_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign count_out = CMPW'(r_count);

    // Sequencer, list count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (done_load) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_status <= n_status;
                        r_rd     <= '0;
                        r_val    <= i_item_value;
                        r_pos    <= pos_a;
                        r_pos2   <= pos2_a;
                        r_count  <= n_idle_count;
                        r_idx    <= n_idx;
                        r_tgt    <= n_tgt;
                        r_dir    <= !cmd_grows;
                        r_ins    <= cmd_grows;
                        r_state  <= n_launch;
                    end
                end
                // Move loop: read the neighbour, then write it one place over
                S_MV_RD: begin
                    if (r_idx == r_tgt) begin
                        if (r_ins) begin
                            r_state <= S_PUT;
                        end else begin
                            r_count <= r_count - CW'(1);
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_MV_WR;
                    end
                end
                S_MV_WR: begin
                    r_idx   <= n_step;
                    r_state <= S_MV_RD;
                end
                S_PUT: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_DONE;
                end
                // Swap: read both, write both crossed over
                S_SW_RD1: begin
                    r_state <= S_SW_RD2;
                end
                S_SW_RD2: begin
                    r_tmp   <= ram_rdata;
                    r_state <= S_SW_WR1;
                end
                S_SW_WR1: begin
                    r_state <= S_SW_WR2;
                end
                S_SW_WR2: begin
                    r_state <= S_DONE;
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_rd    <= ram_rdata;
                    r_state <= S_DONE;
                end
                // Hand the result over once the output register is free
                S_DONE: begin
                    if (done_load) begin
                        o_status     <= r_status;
                        o_read_value <= $signed(r_rd);
                        o_count      <= count_out[COUNT_W-1:0];
                        o_empty      <= (r_count == '0);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks on the engine's own bookkeeping
    `PLE_ASSERT(a_count_bound, (r_count <= CW'(DEPTH)), "list count above depth")
    `PLE_ASSERT(a_busy_after_xfer, (in_xfer |=> o_in_stall), "command transfer did not start work")
    `PLE_ASSERT(a_write_in_list, (ram_we |-> (CW'(ram_waddr) <= r_count)), "RAM write past list end")
    `PLE_ASSERT_ALWAYS(a_reset_clears_out, (!i_rst_n |=> !o_out_valid), "result valid after reset")

endmodule

`default_nettype wire

[dv/tb.sv]
// Testbench for positional_list_engine_top: directed and random list commands.
// Results are checked against a list model kept in the bench itself.
// Depends on ple_pkg and the RTL of positional_list_engine_top.
`timescale 1ns / 1ps

module tb;
    import ple_pkg::*;

    localparam int DEPTH           = 64;
    localparam int IDX_W           = $clog2(DEPTH);
    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 12;
    localparam int MAX_WAIT        = 19;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 160;
    localparam int IDLE_LIMIT      = 3000;
    localparam int POS_MAX         = (1 << POS_W) - 1;
    localparam int POS2_MAX        = (1 << POS2_W) - 1;

    // One result of a list command
    typedef struct {
        t_status                   status;
        logic signed [DATA_W-1:0]  read_value;
        logic        [COUNT_W-1:0] count;
        logic                      empty_flag;
    } t_list_outcome;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic        [CMD_W-1:0]    i_cmd;
    logic        [POS_W-1:0]    i_position;
    logic        [POS2_W-1:0]   i_second_position;
    logic signed [DATA_W-1:0]   i_item_value;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic        [STATUS_W-1:0] o_status;
    logic signed [DATA_W-1:0]   o_read_value;
    logic        [COUNT_W-1:0]  o_count;
    logic                       o_empty;

    // Model of the list contents
    logic signed [DATA_W-1:0] list_vals [DEPTH];
    int                       list_len = 0;

    t_list_outcome list_outcome_q [$];
    int            err_count   = 0;
    bit            tx_idle_en  = 1'b1;
    bit            rx_idle_en  = 1'b1;
    int            rx_hold_left = 0;

    positional_list_engine_top #(
        .DEPTH (DEPTH)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_position        (i_position),
        .i_second_position (i_second_position),
        .i_item_value      (i_item_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_read_value      (o_read_value),
        .o_count           (o_count),
        .o_empty           (o_empty)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // List model helpers: later entries shift up on insert, down on removal
    function automatic void list_insert(int pos, logic signed [DATA_W-1:0] val);
        for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
        list_vals[pos] = val;
        list_len++;
    endfunction

    function automatic void list_remove(int pos);
        for (int i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
        list_len--;
    endfunction

    // Applies one command to the model and returns the outcome it should give
    function automatic t_list_outcome apply_list_cmd(
        logic        [CMD_W-1:0]  cmd,
        logic        [POS_W-1:0]  pos,
        logic        [POS2_W-1:0] pos2,
        logic signed [DATA_W-1:0] val
    );
        t_list_outcome            res;
        logic signed [DATA_W-1:0] tmp;
        bit                       full;
        bit                       empty;
        logic        [IDX_W-1:0]  idx_a;
        logic        [IDX_W-1:0]  idx_b;
        res.status     = ST_OK;
        res.read_value = '0;
        full  = (list_len >= DEPTH);
        empty = (list_len == 0);
        idx_a = pos[IDX_W-1:0];
        idx_b = pos2[IDX_W-1:0];
        case (cmd)
            CMD_INSERT: begin
                if (full) res.status = ST_FULL;
                else if (int'(pos) > list_len) res.status = ST_RANGE;
                else list_insert(int'(pos), val);
            end
            CMD_PUSH_FRONT: begin
                if (full) res.status = ST_FULL;
                else list_insert(0, val);
            end
            CMD_PUSH_BACK: begin
                if (full) res.status = ST_FULL;
                else list_insert(list_len, val);
            end
            CMD_ERASE: begin
                if (empty) res.status = ST_EMPTY;
                else if (int'(pos) >= list_len) res.status = ST_RANGE;
                else list_remove(int'(pos));
            end
            CMD_POP_FRONT: begin
                if (empty) res.status = ST_EMPTY;
                else list_remove(0);
            end
            CMD_POP_BACK: begin
                if (empty) res.status = ST_EMPTY;
                else list_len--;
            end
            CMD_SWAP: begin
                if (empty) res.status = ST_EMPTY;
                else if (int'(pos) >= list_len || int'(pos2) >= list_len)
                    res.status = ST_RANGE;
                else begin
                    tmp              = list_vals[idx_a];
                    list_vals[idx_a] = list_vals[idx_b];
                    list_vals[idx_b] = tmp;
                end
            end
            CMD_READ: begin
                if (empty) res.status = ST_EMPTY;
                else if (int'(pos) >= list_len) res.status = ST_RANGE;
                else res.read_value = list_vals[idx_a];
            end
            CMD_CLEAR: list_len = 0;
            default: ;
        endcase
        res.count      = list_len[COUNT_W-1:0];
        res.empty_flag = (list_len == 0);
        return res;
    endfunction

    // Offers one command, after a random gap when tx_idle_en is set; valid stays high after the transfer
    task automatic send_cmd(
        input logic        [CMD_W-1:0]  cmd,
        input logic        [POS_W-1:0]  pos,
        input logic        [POS2_W-1:0] pos2,
        input logic signed [DATA_W-1:0] val
    );
        int gap;
        gap = tx_idle_en ? int'($urandom_range(0, MAX_WAIT)) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_cmd             <= cmd;
        i_position        <= pos;
        i_second_position <= pos2;
        i_item_value      <= val;
        do @(posedge i_clk); while (o_in_stall);
        list_outcome_q.insert(list_outcome_q.size(), apply_list_cmd(cmd, pos, pos2, val));
    endtask

    // Sender stops offering and waits for every outstanding result
    task automatic pause_sender();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (list_outcome_q.size() != 0);
    endtask

    // Mostly a valid position up to top, sometimes anything the field holds
    function automatic logic [POS_W-1:0] pick_pos(int top);
        if (top >= 0 && $urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, top));
        return POS_W'($urandom_range(0, POS_MAX));
    endfunction

    function automatic logic [POS2_W-1:0] pick_pos2(int top);
        if (top >= 0 && $urandom_range(0, 99) < 85)
            return POS2_W'($urandom_range(0, (top > POS2_MAX) ? POS2_MAX : top));
        return POS2_W'($urandom_range(0, POS2_MAX));
    endfunction

    // Empty-list refusals, extreme values, range checks, swap cases, odd codes
    task automatic test_directed();
        send_cmd(CMD_READ, 0, 0, 0);
        send_cmd(CMD_ERASE, 0, 0, 0);
        send_cmd(CMD_POP_FRONT, 0, 0, 0);
        send_cmd(CMD_POP_BACK, 0, 0, 0);
        send_cmd(CMD_SWAP, 0, 0, 0);
        send_cmd(CMD_PUSH_FRONT, 0, 0, 32'sh8000_0000);
        send_cmd(CMD_PUSH_BACK, 0, 0, 32'sh7fff_ffff);
        send_cmd(CMD_INSERT, 2, 0, 0);
        send_cmd(CMD_INSERT, 0, 0, -1);
        send_cmd(CMD_INSERT, 5, 0, 32'sh1234_5678);
        send_cmd(CMD_INSERT, POS_W'(POS_MAX), POS2_W'(POS2_MAX), -1);
        for (int i = 0; i < 4; i++) send_cmd(CMD_READ, POS_W'(i), 0, 0);
        send_cmd(CMD_READ, 4, 0, 0);
        send_cmd(CMD_READ, POS_W'(POS_MAX), 0, 0);
        send_cmd(CMD_SWAP, 1, 1, 0);
        send_cmd(CMD_SWAP, 0, 3, 0);
        send_cmd(CMD_SWAP, 0, POS2_W'(POS2_MAX), 0);
        send_cmd(CMD_SWAP, 100, 0, 0);
        send_cmd(CMD_ERASE, 1, 0, 0);
        send_cmd(CMD_ERASE, 3, 0, 0);
        send_cmd(4'd9, 0, 0, 0);
        send_cmd(4'd15, POS_W'(POS_MAX), POS2_W'(POS2_MAX), -1);
        send_cmd(CMD_CLEAR, 0, 0, 0);
        send_cmd(CMD_CLEAR, 0, 0, 0);
        pause_sender();
    endtask

    // Fill to DEPTH, hit the full refusals (full wins over range), then empty it
    task automatic test_full_list();
        while (list_len < DEPTH) send_cmd(CMD_PUSH_BACK, 0, 0, $urandom);
        send_cmd(CMD_PUSH_FRONT, 0, 0, $urandom);
        send_cmd(CMD_PUSH_BACK, 0, 0, $urandom);
        send_cmd(CMD_INSERT, 0, 0, $urandom);
        send_cmd(CMD_INSERT, 100, 0, $urandom);
        send_cmd(CMD_READ, POS_W'(DEPTH - 1), 0, 0);
        send_cmd(CMD_READ, POS_W'(DEPTH), 0, 0);
        send_cmd(CMD_SWAP, 0, POS2_W'(DEPTH - 1), 0);
        send_cmd(CMD_ERASE, POS_W'(DEPTH - 1), 0, 0);
        send_cmd(CMD_INSERT, POS_W'(DEPTH - 1), 0, $urandom);
        send_cmd(CMD_ERASE, 0, 0, 0);
        send_cmd(CMD_INSERT, 0, 0, $urandom);
        while (list_len > 0) send_cmd((list_len % 2) ? CMD_POP_FRONT : CMD_POP_BACK, 0, 0, 0);
        send_cmd(CMD_POP_FRONT, 0, 0, 0);
        pause_sender();
    endtask

    // Receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        tx_idle_en   = 1'b0;
        rx_hold_left = HOLD_OFF_CYCLES;
        for (int i = 0; i < 16; i++) send_cmd(CMD_PUSH_BACK, 0, 0, $urandom);
        pause_sender();
        tx_idle_en = 1'b1;
    endtask

    // Random commands in phases that lean towards growing or shrinking the list
    task automatic test_random();
        int                       r;
        int                       grow;
        logic        [CMD_W-1:0]  cmd;
        logic        [POS_W-1:0]  pos;
        logic        [POS2_W-1:0] pos2;
        logic signed [DATA_W-1:0] val;
        for (int phase = 0; phase < 8; phase++) begin
            grow       = (phase % 2) ? 30 : 65;
            tx_idle_en = (phase % 4 != 1);
            rx_idle_en = (phase % 4 != 2) && (phase != 7);
            if (phase == 7) tx_idle_en = 1'b0;
            for (int n = 0; n < 95; n++) begin
                r    = $urandom_range(0, 99);
                val  = $urandom;
                pos  = pick_pos(list_len - 1);
                pos2 = pick_pos2(list_len - 1);
                if (r < grow) begin
                    case ($urandom_range(0, 2))
                        0: begin
                            cmd = CMD_INSERT;
                            pos = pick_pos(list_len);
                        end
                        1: cmd = CMD_PUSH_FRONT;
                        default: cmd = CMD_PUSH_BACK;
                    endcase
                end else if (r < 95) begin
                    case ($urandom_range(0, 4))
                        0: cmd = CMD_ERASE;
                        1: cmd = CMD_POP_FRONT;
                        2: cmd = CMD_POP_BACK;
                        3: cmd = CMD_SWAP;
                        default: cmd = CMD_READ;
                    endcase
                end else if (r < 97) begin
                    cmd = CMD_CLEAR;
                end else begin
                    cmd = CMD_W'($urandom_range(9, 15));
                end
                send_cmd(cmd, pos, pos2, val);
            end
            pause_sender();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Result side: check each transfer, then draw the next stall
    initial begin : result_sink
        int            wait_left;
        t_list_outcome exp_res;
        wait_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (list_outcome_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    err_count++;
                end else begin
                    exp_res = list_outcome_q[0];
                    list_outcome_q.delete(0);
                    if (o_status !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d", exp_res.status, o_status);
                        err_count++;
                    end
                    if (o_read_value !== exp_res.read_value) begin
                        $error("read_value: expected %0d, actual %0d",
                               exp_res.read_value, o_read_value);
                        err_count++;
                    end
                    if (o_count !== exp_res.count) begin
                        $error("count: expected %0d, actual %0d", exp_res.count, o_count);
                        err_count++;
                    end
                    if (o_empty !== exp_res.empty_flag) begin
                        $error("empty: expected %0d, actual %0d",
                               exp_res.empty_flag, o_empty);
                        err_count++;
                    end
                end
                wait_left = rx_idle_en ? int'($urandom_range(0, MAX_WAIT)) : 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_out_stall <= 1'b1;
            end else if (wait_left > 0) begin
                wait_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin : watchdog
        static int quiet_cycles = 0;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("positional_list_engine_top test failed");
            $finish;
        end
    end

    // Test sequence
    initial begin
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_cmd             <= '0;
        i_position        <= '0;
        i_second_position <= '0;
        i_item_value      <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_list();
        test_backpressure();
        test_random();
        pause_sender();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && list_outcome_q.size() == 0)
            $display("positional_list_engine_top test passed");
        else
            $display("positional_list_engine_top test failed");
        $finish;
    end

endmodule
